### rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 hash engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

	localparam int unsigned LEN_COUNT_BITS_DEF = 61;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// top level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PAD,
		ST_FILL,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_SEND
	} sha_state_t;

	// padding progress of the current message
	typedef enum logic [1:0] {
		PH_NONE,
		PH_OWED,
		PH_FILL,
		PH_FINAL
	} sha_phase_t;

	// commands from the sequencer to the compression unit
	typedef struct packed {
		logic        push;
		logic [31:0] push_word;
		logic        start;
		logic        init_chain;
		logic        rotate;
	} sha_cmd_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] k_word(input logic [5:0] idx);
		logic [31:0] r;
		case (idx)
			6'd0:  r = 32'h428a2f98;
			6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;
			6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;
			6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;
			6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;
			6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;
			6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;
			6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;
			6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;
			6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;
			6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;
			6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;
			6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;
			6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;
			6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;
			6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;
			6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;
			6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;
			6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;
			6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;
			6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;
			6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;
			6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;
			6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sha_in_if.sv
// ----------------------------------------------------------------------------
// sha_in_if
// message byte channel: valid/ready handshake with one byte request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

`default_nettype wire

### rtl/core/sha_out_if.sv
// ----------------------------------------------------------------------------
// sha_out_if
// digest word channel: valid/ready handshake with one digest word request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

### rtl/core/sha_compress.sv
// ----------------------------------------------------------------------------
// sha_compress
// schedule window, one-round-per-cycle compression unit and chaining value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha_compress import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha_cmd_t    cmd,
	output logic             done,
	output logic [31:0]      chain_word
);

	logic [31:0] win_q [16];
	logic [31:0] var_q [8];
	logic [31:0] chain_q [8];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        fold_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] w_next;

	// one round; window slot 0 always holds the word of the current round
	always_comb begin
		ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		mj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1 = var_q[7] + bsig1(var_q[4]) + ch + k_word(rnd_q) + win_q[0];
		t2 = bsig0(var_q[0]) + mj;
		w_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	end

	// schedule window as a shift line
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= cmd.push_word;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
		end else if (busy_q) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fold_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			fold_q <= busy_q && (rnd_q == 6'd63);
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) busy_q <= 1'b0;
			end
		end
	end

	// chaining value: initial load, feed-forward add, rotate for readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(3'(i));
		end else if (cmd.init_chain) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(3'(i));
		end else if (cmd.rotate) begin
			for (int i = 0; i < 7; i++) chain_q[i] <= chain_q[i + 1];
			chain_q[7] <= chain_q[0];
		end else if (fold_q) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
		end
	end

	assign done       = fold_q;
	assign chain_word = chain_q[0];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (!busy_q && !fold_q))
		else $error("compression started while a block is in flight");

	a_fold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rnd_q == 6'd63) |=> (fold_q && !busy_q))
		else $error("feed-forward add did not follow the last round");

	a_push_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!busy_q && !fold_q))
		else $error("schedule word pushed during compression");

endmodule

`default_nettype wire

### rtl/core/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine
// streaming sha-256: message bytes in, eight digest words out per message
// ----------------------------------------------------------------------------
// A request on msg carries at most one message byte; end_of_message closes the
// message after that byte. Byte requests are taken back to back, except the
// 64th byte of a block, after which the block is compressed by a single round
// unit at one round per cycle, 64 rounds and then the chaining add, with
// msg.ready low throughout. The end request starts the padding sequencer: the
// 0x80 word, zero words up to word 13, an idle step at the length slot, the
// two bit-length words, then one compression (two when 56 or more bytes sit
// in the last block, the first of them filled with zero words up to word 15).
// The eight digest words then leave on digest, word 0 first, one per accepted
// request; msg.ready comes back after the eighth. A request with neither a
// byte nor an end mark is taken and does nothing. The byte count wraps at
// 2**LEN_COUNT_BITS and the appended length is eight times the wrapped count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_hash_engine import sha_pkg::*; #(
	parameter int unsigned LEN_COUNT_BITS = LEN_COUNT_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sha_in_if.sink     msg,
	sha_out_if.source  digest
);

	sha_state_t              st_q;
	sha_state_t              st_d;
	sha_phase_t              ph_q;
	logic [LEN_COUNT_BITS-1:0] count_q;
	logic [3:0]              widx_q;    // words pushed into the current block
	logic [2:0]              idx_q;     // digest word being sent
	logic [31:0]             acc_q;     // partial big-endian word

	sha_cmd_t    cmd;
	logic        core_done;
	logic [31:0] chain_word;

	logic        msg_acc;
	logic        dig_acc;
	logic [1:0]  bpos;
	logic        word_full;
	logic        block_full;
	logic [31:0] byte_word;
	logic [31:0] pad_word;
	logic [63:0] bit_len;

	assign msg_acc    = msg.valid && msg.ready;
	assign dig_acc    = digest.valid && digest.ready;
	assign bpos       = count_q[1:0];
	assign word_full  = msg.has_byte && (bpos == 2'd3);
	assign block_full = word_full && (widx_q == 4'd15);
	assign byte_word  = {acc_q[31:8], msg.data_byte};
	assign bit_len    = 64'(count_q) << 3;

	// pad byte lands right after the last message byte, rest of word is zero
	always_comb begin
		case (bpos)
			2'd0:    pad_word = {PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[31:24], PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[31:16], PAD_BYTE, 8'h0};
			2'd3:    pad_word = {acc_q[31:8], PAD_BYTE};
			default: pad_word = {PAD_BYTE, 24'h0};
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (msg_acc) begin
					if (block_full) st_d = ST_HASH;
					else if (msg.end_of_message) st_d = ST_PAD;
				end
			end
			ST_HASH: begin
				if (core_done) begin
					case (ph_q)
						PH_FINAL: st_d = ST_SEND;
						PH_OWED:  st_d = ST_PAD;
						PH_FILL:  st_d = ST_FILL;
						default:  st_d = ST_IDLE;
					endcase
				end
			end
			ST_PAD: begin
				st_d = (widx_q == 4'd15) ? ST_HASH : ST_FILL;
			end
			ST_FILL: begin
				if (widx_q == 4'd14) st_d = ST_LEN_HI;
				else if (widx_q == 4'd15) st_d = ST_HASH;
			end
			ST_LEN_HI: st_d = ST_LEN_LO;
			ST_LEN_LO: st_d = ST_HASH;
			ST_SEND: begin
				if (dig_acc && (idx_q == 3'd7)) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs and commands to the compression unit
	always_comb begin
		cmd          = '0;
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		case (st_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg_acc && word_full) begin
					cmd.push      = 1'b1;
					cmd.push_word = byte_word;
					cmd.start     = block_full;
				end
			end
			ST_PAD: begin
				cmd.push      = 1'b1;
				cmd.push_word = pad_word;
				cmd.start     = (widx_q == 4'd15);
			end
			ST_FILL: begin
				// zero words up to the length slot, or to the end of an overflow block
				if (widx_q != 4'd14) begin
					cmd.push  = 1'b1;
					cmd.start = (widx_q == 4'd15);
				end
			end
			ST_LEN_HI: begin
				cmd.push      = 1'b1;
				cmd.push_word = bit_len[63:32];
			end
			ST_LEN_LO: begin
				cmd.push      = 1'b1;
				cmd.push_word = bit_len[31:0];
				cmd.start     = 1'b1;
			end
			ST_SEND: begin
				digest.valid = 1'b1;
				if (dig_acc) begin
					cmd.rotate     = 1'b1;
					cmd.init_chain = (idx_q == 3'd7);
				end
			end
			default: ;
		endcase
	end

	assign digest.digest_word = chain_word;
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ph_q    <= PH_NONE;
			count_q <= '0;
			widx_q  <= '0;
			idx_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cmd.push) widx_q <= widx_q + 4'd1;
			if (dig_acc) idx_q <= idx_q + 3'd1;
			case (st_q)
				ST_IDLE: begin
					if (msg_acc && msg.has_byte) count_q <= count_q + LEN_COUNT_BITS'(1);
					if (msg_acc && msg.end_of_message) ph_q <= PH_OWED;
				end
				ST_PAD:    ph_q <= PH_FILL;
				ST_LEN_LO: ph_q <= PH_FINAL;
				ST_SEND: begin
					if (dig_acc && (idx_q == 3'd7)) begin
						count_q <= '0;
						ph_q    <= PH_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	// byte packing, big-endian; a new word starts clean
	always_ff @(posedge clk) begin
		if (msg_acc && msg.has_byte) begin
			case (bpos)
				2'd0:    acc_q <= {msg.data_byte, 24'h0};
				2'd1:    acc_q[23:16] <= msg.data_byte;
				2'd2:    acc_q[15:8] <= msg.data_byte;
				2'd3:    acc_q[7:0] <= msg.data_byte;
				default: acc_q <= {msg.data_byte, 24'h0};
			endcase
		end
	end

	sha_compress u_compress (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.done       (core_done),
		.chain_word (chain_word)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid)
		else $error("byte request taken while digest words are pending");

	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (st_q == ST_HASH))
		else $error("compression finished outside the hash wait");

	a_len_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LEN_HI) |-> (widx_q == 4'd14))
		else $error("length words not aligned to the end of the block");

	a_send_run: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && !digest.last_word) |=> digest.valid)
		else $error("digest output stopped before the eighth word");

	a_clean_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && digest.last_word) |=> (widx_q == 4'd0 && count_q == '0
			&& ph_q == PH_NONE))
		else $error("message state not cleared after the digest");

endmodule

`default_nettype wire
